// ===== rtl/core/e2i_pkg.sv =====
`timescale 1ns / 1ps
package e2i_pkg;
    localparam int EpochW = 39;
    localparam logic signed [EpochW-1:0] SecMin = -39'sd62167219200;
    localparam logic signed [EpochW-1:0] SecMax = 39'sd253402300799;
    localparam logic signed [EpochW-1:0] DayMin = -39'sd719528;
    localparam logic signed [EpochW-1:0] DayMax = 39'sd2932896;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChDash  = 8'h2d;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChColon = 8'h3a;
    localparam logic [4:0] LenDate = 5'd10;
    localparam logic [4:0] LenFull = 5'd19;

    typedef enum logic {
        OP_DATE = 1'b0,
        OP_TIME = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [3:0] y3;
        logic [3:0] y2;
        logic [3:0] y1;
        logic [3:0] y0;
        logic [3:0] mo1;
        logic [3:0] mo0;
        logic [3:0] d1;
        logic [3:0] d0;
        logic [3:0] h1;
        logic [3:0] h0;
        logic [3:0] mi1;
        logic [3:0] mi0;
        logic [3:0] s1;
        logic [3:0] s0;
        logic       full;
    } t_digits;
endpackage

// ===== rtl/core/e2i_if.sv =====
`timescale 1ns / 1ps
interface e2i_in_if;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic signed [38:0] epoch_value;
    modport source (output valid, output opcode, output epoch_value, input ready);
    modport sink   (input valid, input opcode, input epoch_value, output ready);
endinterface

interface e2i_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;
    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== rtl/core/e2i_conv.sv =====
`timescale 1ns / 1ps
module e2i_conv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_opcode,
    input  logic signed [38:0]        i_epoch_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output e2i_pkg::t_digits          o_digits
);
    import e2i_pkg::*;

    localparam int NStg = 11;
    localparam logic [31:0] Rcp675  = 32'd3257812231;
    localparam logic [23:0] RcpEra  = 24'd15051803;
    localparam logic [12:0] Rcp225  = 13'd4661;
    localparam logic [10:0] Rcp15   = 11'd1093;
    localparam logic [17:0] Rcp1460 = 18'd183860;
    localparam logic [18:0] Rcp365  = 19'd367720;
    localparam logic [10:0] Rcp153  = 11'd1714;
    localparam logic [10:0] Rcp5    = 11'd1639;
    localparam logic [14:0] Rcp1000 = 15'd16778;
    localparam logic [13:0] Rcp100  = 14'd10486;
    localparam logic [13:0] Rcp10   = 14'd13108;

    logic [NStg-1:0] r_v;
    logic [NStg-1:0] adv;

    // stage 1: clamp
    logic               r1_full;
    logic signed [38:0] r1_v;
    // stage 2: seconds to days by reciprocal
    logic               r2_full;
    logic [21:0]        r2_q;
    logic [16:0]        r2_ulo;
    logic signed [22:0] r2_day;
    // stage 3: shifted day count, time of day
    logic               r3_full;
    logic [21:0]        r3_z;
    logic [16:0]        r3_tod;
    // stage 4: era, hour
    logic               r4_full;
    logic [4:0]         r4_era;
    logic [21:0]        r4_z;
    logic [4:0]         r4_h;
    logic [16:0]        r4_tod;
    // stage 5: day of era, seconds within hour
    logic               r5_full;
    logic [4:0]         r5_era;
    logic [17:0]        r5_doe;
    logic [4:0]         r5_h;
    logic [11:0]        r5_rem;
    // stage 6: year numerator, minute
    logic               r6_full;
    logic [4:0]         r6_era;
    logic [17:0]        r6_doe;
    logic [17:0]        r6_t;
    logic [4:0]         r6_h;
    logic [11:0]        r6_rem;
    logic [5:0]         r6_mi;
    // stage 7: year of era, second
    logic               r7_full;
    logic [4:0]         r7_era;
    logic [17:0]        r7_doe;
    logic [8:0]         r7_yoe;
    logic [4:0]         r7_h;
    logic [5:0]         r7_mi;
    logic [5:0]         r7_s;
    // stage 8: day of year
    logic               r8_full;
    logic [4:0]         r8_era;
    logic [8:0]         r8_yoe;
    logic [8:0]         r8_doy;
    logic [4:0]         r8_h;
    logic [5:0]         r8_mi;
    logic [5:0]         r8_s;
    // stage 9: month index
    logic               r9_full;
    logic [4:0]         r9_era;
    logic [8:0]         r9_yoe;
    logic [8:0]         r9_doy;
    logic [3:0]         r9_mp;
    logic [4:0]         r9_h;
    logic [5:0]         r9_mi;
    logic [5:0]         r9_s;
    // stage 10: year, month, day
    logic               r10_full;
    logic [13:0]        r10_y;
    logic [3:0]         r10_m;
    logic [4:0]         r10_d;
    logic [4:0]         r10_h;
    logic [5:0]         r10_mi;
    logic [5:0]         r10_s;
    // stage 11: decimal digits
    t_digits            r11_dg;

    function automatic logic [3:0] tens_of(input logic [5:0] x);
        logic [9:0] p;
        p = 10'(x) * 10'd13;
        return 4'(p[9:7]);
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] x);
        logic [5:0] t;
        t = 6'(tens_of(x));
        return 4'(x - t * 6'd10);
    endfunction

    always_comb begin
        adv[NStg-1] = !r_v[NStg-1] || i_ready;
        for (int k = NStg - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end
    assign o_ready  = adv[0];
    assign o_valid  = r_v[NStg-1];
    assign o_digits = r11_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NStg; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    logic signed [38:0] n1_v;
    always_comb begin
        n1_v = i_epoch_value;
        if (i_opcode == OP_TIME) begin
            if (n1_v < SecMin) n1_v = SecMin;
            if (n1_v > SecMax) n1_v = SecMax;
        end else begin
            if (n1_v < DayMin) n1_v = DayMin;
            if (n1_v > DayMax) n1_v = DayMax;
        end
    end

    // shifted seconds are nonnegative: s + 62167219200 < 2^39
    logic [38:0] s2_u;
    logic [63:0] s2_p;
    always_comb begin
        s2_u = 39'(r1_v - SecMin);
        s2_p = 64'(s2_u[38:7]) * 64'(Rcp675);
    end

    logic [38:0]        s3_qs;
    logic [16:0]        s3_tod;
    logic signed [22:0] s3_zd;
    logic [21:0]        s3_z;
    always_comb begin
        s3_qs  = 39'(r2_q) * 39'd86400;
        s3_tod = r2_ulo - s3_qs[16:0];
        s3_zd  = r2_day + 23'sd865565;
        s3_z   = r2_full ? (r2_q + 22'd146037) : s3_zd[21:0];
    end

    logic [45:0] s4_pe;
    logic [25:0] s4_ph;
    always_comb begin
        s4_pe = 46'(r3_z) * 46'(RcpEra);
        s4_ph = 26'(r3_tod[16:4]) * 26'(Rcp225);
    end

    logic [21:0] s5_es;
    logic [16:0] s5_hs;
    always_comb begin
        s5_es = 22'(r4_era) * 22'd146097;
        s5_hs = 17'(r4_h) * 17'd3600;
    end

    logic [35:0] s6_pa;
    logic [17:0] s6_t;
    logic [20:0] s6_pm;
    always_comb begin
        s6_pa = 36'(r5_doe) * 36'(Rcp1460);
        s6_t  = r5_doe - 18'(s6_pa[35:28]) + 18'(r5_doe >= 18'd36524)
              + 18'(r5_doe >= 18'd73048) + 18'(r5_doe >= 18'd109572);
        s6_pm = 21'(r5_rem[11:2]) * 21'(Rcp15);
    end

    logic [36:0] s7_py;
    logic [11:0] s7_ms;
    always_comb begin
        s7_py = 37'(r6_t) * 37'(Rcp365);
        s7_ms = 12'(r6_mi) * 12'd60;
    end

    logic [17:0] s8_ys;
    always_comb begin
        s8_ys = 18'(r7_yoe) * 18'd365 + 18'(r7_yoe[8:2])
              - 18'(r7_yoe >= 9'd100) - 18'(r7_yoe >= 9'd200) - 18'(r7_yoe >= 9'd300);
    end

    logic [21:0] s9_pm;
    always_comb begin
        s9_pm = (22'(r8_doy) * 22'd5 + 22'd2) * 22'(Rcp153);
    end

    logic [21:0] s10_pd;
    logic [8:0]  s10_dd;
    logic [3:0]  s10_m;
    always_comb begin
        s10_pd = (22'(r9_mp) * 22'd153 + 22'd2) * 22'(Rcp5);
        s10_dd = s10_pd[21:13];
        s10_m  = (r9_mp < 4'd10) ? r9_mp + 4'd3 : r9_mp - 4'd9;
    end

    logic [27:0] s11_p3;
    logic [26:0] s11_p2;
    logic [26:0] s11_p1;
    logic [3:0]  s11_q3;
    logic [6:0]  s11_q2;
    logic [9:0]  s11_q1;
    always_comb begin
        s11_p3 = 28'(r10_y) * 28'(Rcp1000);
        s11_p2 = 27'(r10_y) * 27'(Rcp100);
        s11_p1 = 27'(r10_y) * 27'(Rcp10);
        s11_q3 = s11_p3[27:24];
        s11_q2 = s11_p2[26:20];
        s11_q1 = s11_p1[26:17];
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_full <= i_opcode;
            r1_v    <= n1_v;
        end
        if (adv[1]) begin
            r2_full <= r1_full;
            r2_q    <= s2_p[62:41];
            r2_ulo  <= s2_u[16:0];
            r2_day  <= r1_v[22:0];
        end
        if (adv[2]) begin
            r3_full <= r2_full;
            r3_z    <= s3_z;
            r3_tod  <= r2_full ? s3_tod : '0;
        end
        if (adv[3]) begin
            r4_full <= r3_full;
            r4_era  <= s4_pe[45:41];
            r4_z    <= r3_z;
            r4_h    <= s4_ph[24:20];
            r4_tod  <= r3_tod;
        end
        if (adv[4]) begin
            r5_full <= r4_full;
            r5_era  <= r4_era;
            r5_doe  <= 18'(r4_z - s5_es);
            r5_h    <= r4_h;
            r5_rem  <= 12'(r4_tod - s5_hs);
        end
        if (adv[5]) begin
            r6_full <= r5_full;
            r6_era  <= r5_era;
            r6_doe  <= r5_doe;
            r6_t    <= s6_t;
            r6_h    <= r5_h;
            r6_rem  <= r5_rem;
            r6_mi   <= s6_pm[19:14];
        end
        if (adv[6]) begin
            r7_full <= r6_full;
            r7_era  <= r6_era;
            r7_doe  <= r6_doe;
            r7_yoe  <= s7_py[35:27];
            r7_h    <= r6_h;
            r7_mi   <= r6_mi;
            r7_s    <= 6'(r6_rem - s7_ms);
        end
        if (adv[7]) begin
            r8_full <= r7_full;
            r8_era  <= r7_era;
            r8_yoe  <= r7_yoe;
            r8_doy  <= 9'(r7_doe - s8_ys);
            r8_h    <= r7_h;
            r8_mi   <= r7_mi;
            r8_s    <= r7_s;
        end
        if (adv[8]) begin
            r9_full <= r8_full;
            r9_era  <= r8_era;
            r9_yoe  <= r8_yoe;
            r9_doy  <= r8_doy;
            r9_mp   <= s9_pm[21:18];
            r9_h    <= r8_h;
            r9_mi   <= r8_mi;
            r9_s    <= r8_s;
        end
        if (adv[9]) begin
            r10_full <= r9_full;
            r10_y    <= 14'(r9_yoe) + 14'(r9_era) * 14'd400 - 14'd400
                      + ((s10_m <= 4'd2) ? 14'd1 : 14'd0);
            r10_m    <= s10_m;
            r10_d    <= 5'(r9_doy - s10_dd + 9'd1);
            r10_h    <= r9_h;
            r10_mi   <= r9_mi;
            r10_s    <= r9_s;
        end
        if (adv[10]) begin
            r11_dg.full <= r10_full;
            r11_dg.y3   <= s11_q3;
            r11_dg.y2   <= 4'(s11_q2 - 7'(s11_q3) * 7'd10);
            r11_dg.y1   <= 4'(s11_q1 - 10'(s11_q2) * 10'd10);
            r11_dg.y0   <= 4'(r10_y - 14'(s11_q1) * 14'd10);
            r11_dg.mo1  <= tens_of(6'(r10_m));
            r11_dg.mo0  <= ones_of(6'(r10_m));
            r11_dg.d1   <= tens_of(6'(r10_d));
            r11_dg.d0   <= ones_of(6'(r10_d));
            r11_dg.h1   <= tens_of(6'(r10_h));
            r11_dg.h0   <= ones_of(6'(r10_h));
            r11_dg.mi1  <= tens_of(r10_mi);
            r11_dg.mi0  <= ones_of(r10_mi);
            r11_dg.s1   <= tens_of(r10_s);
            r11_dg.s0   <= ones_of(r10_s);
        end
    end
endmodule

// ===== rtl/core/e2i_ser.sv =====
`timescale 1ns / 1ps
module e2i_ser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  e2i_pkg::t_digits i_digits,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_text_char,
    output logic             o_last_char
);
    import e2i_pkg::*;

    logic            r_busy;
    logic [4:0]      r_idx;
    t_digits         r_dg;
    logic [4:0]      len;
    logic [7:0]      ch;
    logic            last;
    logic            done;

    assign len  = r_dg.full ? LenFull : LenDate;
    assign last = (r_idx == len - 5'd1);
    assign done = r_busy && i_ready && last;
    assign o_ready = !r_busy || done;
    assign o_valid = r_busy;
    assign o_text_char = ch;
    assign o_last_char = last;

    always_comb begin
        case (r_idx)
            5'd0:  ch = ChZero + 8'(r_dg.y3);
            5'd1:  ch = ChZero + 8'(r_dg.y2);
            5'd2:  ch = ChZero + 8'(r_dg.y1);
            5'd3:  ch = ChZero + 8'(r_dg.y0);
            5'd5:  ch = ChZero + 8'(r_dg.mo1);
            5'd6:  ch = ChZero + 8'(r_dg.mo0);
            5'd8:  ch = ChZero + 8'(r_dg.d1);
            5'd9:  ch = ChZero + 8'(r_dg.d0);
            5'd10: ch = ChSpace;
            5'd11: ch = ChZero + 8'(r_dg.h1);
            5'd12: ch = ChZero + 8'(r_dg.h0);
            5'd14: ch = ChZero + 8'(r_dg.mi1);
            5'd15: ch = ChZero + 8'(r_dg.mi0);
            5'd17: ch = ChZero + 8'(r_dg.s1);
            5'd18: ch = ChZero + 8'(r_dg.s0);
            5'd13, 5'd16: ch = ChColon;
            default: ch = ChDash;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_valid && o_ready) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_dg <= i_digits;
    end
endmodule

// ===== rtl/core/epoch_to_iso_datetime_text.sv =====
`timescale 1ns / 1ps
// Converts a day count (opcode 0) or second count (opcode 1) since 1970-01-01 into
// ISO text, one character per cycle while the output is ready: 10 characters for a
// date, 19 for date and time. Conversion runs in an eleven-stage pipeline that takes
// an item each cycle unless back-pressure stalls it; the output serializer, once busy,
// takes a new item only as the last character of its current item is taken.
module epoch_to_iso_datetime_text (
    input  logic    i_clk,
    input  logic    i_rst_n,
    e2i_in_if.sink  i_in,
    e2i_out_if.source o_out
);
    import e2i_pkg::*;

    logic    cv_valid;
    logic    cv_ready;
    t_digits cv_digits;

    e2i_conv u_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_opcode      (i_in.opcode),
        .i_epoch_value (i_in.epoch_value),
        .o_valid       (cv_valid),
        .i_ready       (cv_ready),
        .o_digits      (cv_digits)
    );

    e2i_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cv_valid),
        .o_ready     (cv_ready),
        .i_digits    (cv_digits),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_text_char (o_out.text_char),
        .o_last_char (o_out.last_char)
    );

`ifndef SYNTHESIS
    a_char_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.text_char >= ChSpace && o_out.text_char <= ChColon))
        else $error("bad char");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.text_char))
        else $error("output changed while stalled");
`endif
endmodule

// ===== sim/e2i_checker.sv =====
`timescale 1ns / 1ps
module e2i_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    e2i_in_if        i_in,
    e2i_out_if       i_out,
    output int       o_fail_count,
    output int       o_pending
);
    import e2i_pkg::*;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_char;

    t_char char_queue[$];
    int    fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = char_queue.size();

    function automatic logic [7:0] digit(longint val);
        return ChZero + 8'(val % 10);
    endfunction

    function automatic void civil_date(input longint days, ref logic [7:0] txt[19]);
        longint z, era, doe, yoe, doy, mp, d, m, y;
        z   = days + 719468;
        era = (z >= 0 ? z : z - 146096) / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        m   = mp + (mp < 10 ? 3 : -9);
        y   = yoe + era * 400 + (m <= 2 ? 1 : 0);
        txt[0] = digit(y / 1000);
        txt[1] = digit(y / 100);
        txt[2] = digit(y / 10);
        txt[3] = digit(y);
        txt[4] = ChDash;
        txt[5] = digit(m / 10);
        txt[6] = digit(m);
        txt[7] = ChDash;
        txt[8] = digit(d / 10);
        txt[9] = digit(d);
    endfunction

    task automatic predict_text(input t_opcode op, input logic signed [38:0] raw);
        logic [7:0] txt[19];
        longint     v, days, tod;
        int         len;
        v = longint'(raw);
        if (op == OP_DATE) begin
            if (v < longint'(DayMin)) v = longint'(DayMin);
            if (v > longint'(DayMax)) v = longint'(DayMax);
            civil_date(v, txt);
            len = 10;
        end else begin
            if (v < longint'(SecMin)) v = longint'(SecMin);
            if (v > longint'(SecMax)) v = longint'(SecMax);
            days = v / 86400;
            tod  = v % 86400;
            if (tod < 0) begin
                days -= 1;
                tod  += 86400;
            end
            civil_date(days, txt);
            txt[10] = ChSpace;
            txt[11] = digit(tod / 36000);
            txt[12] = digit(tod / 3600);
            txt[13] = ChColon;
            txt[14] = digit((tod % 3600) / 600);
            txt[15] = digit((tod % 3600) / 60);
            txt[16] = ChColon;
            txt[17] = digit((tod % 60) / 10);
            txt[18] = digit(tod % 60);
            len = 19;
        end
        for (int k = 0; k < len; k++) begin
            char_queue.push_back({txt[k], k == len - 1});
        end
    endtask

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                predict_text(t_opcode'(i_in.opcode), i_in.epoch_value);
            end
            if (i_out.valid && i_out.ready) begin
                if (char_queue.size() == 0) begin
                    report($sformatf("unexpected char %h", i_out.text_char));
                end else begin
                    want = char_queue.pop_front();
                    if (i_out.text_char !== want.text_char) begin
                        report($sformatf("text_char %h want %h", i_out.text_char,
                                         want.text_char));
                    end
                    if (i_out.last_char !== want.last_char) begin
                        report($sformatf("last_char %b want %b", i_out.last_char,
                                         want.last_char));
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import e2i_pkg::*;

    localparam int WatchdogLimit = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    e2i_in_if  in_ch ();
    e2i_out_if out_ch ();

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    bit stim_done;
    int quiet_cycles;

    epoch_to_iso_datetime_text i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    e2i_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.opcode      = 1'b0;
        in_ch.epoch_value = '0;
        out_ch.ready      = 1'b0;
        send_idle_pct     = 26;
        recv_idle_pct     = 78;
        hold_off          = 1'b0;
        stim_done         = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        repeat (60) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic send_item(input t_opcode op, input logic signed [38:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.epoch_value <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic signed [38:0] random_epoch(input t_opcode op);
        logic signed [38:0] val;
        case ($urandom_range(9))
            0: val = 39'({$urandom, $urandom});
            1: val = (op == OP_DATE) ? DayMin - 39'sd1 : SecMin - 39'sd1;
            2: val = (op == OP_DATE) ? DayMax + 39'sd1 : SecMax + 39'sd1;
            3: val = 39'sd86400 * ($signed(39'($urandom_range(200000))) - 39'sd100000)
                     - 39'($urandom_range(1));
            default: begin
                if (op == OP_DATE) begin
                    val = DayMin + 39'($urandom_range(3652424));
                end else begin
                    val = SecMin + 39'({$urandom_range(73), $urandom});
                    if (val > SecMax) val = SecMax - 39'($urandom_range(100000));
                end
            end
        endcase
        return val;
    endfunction

    task automatic run_random(input int count);
        t_opcode op;
        for (int k = 0; k < count; k++) begin
            op = t_opcode'($urandom_range(1));
            send_item(op, random_epoch(op));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_DATE, 39'sd0);
        send_item(OP_DATE, -39'sd1);
        send_item(OP_DATE, DayMin);
        send_item(OP_DATE, DayMin - 39'sd1);
        send_item(OP_DATE, DayMax);
        send_item(OP_DATE, DayMax + 39'sd1);
        send_item(OP_DATE, {1'b1, 38'd0});
        send_item(OP_DATE, {1'b0, {38{1'b1}}});
        send_item(OP_DATE, 39'sd11016);
        send_item(OP_DATE, 39'sd59);
        send_item(OP_TIME, 39'sd0);
        send_item(OP_TIME, -39'sd1);
        send_item(OP_TIME, -39'sd86400);
        send_item(OP_TIME, -39'sd86401);
        send_item(OP_TIME, SecMin);
        send_item(OP_TIME, SecMin - 39'sd1);
        send_item(OP_TIME, SecMax);
        send_item(OP_TIME, SecMax + 39'sd1);
        send_item(OP_TIME, {1'b1, 38'd0});
        send_item(OP_TIME, {39{1'b1}});
        send_item(OP_TIME, {1'b0, {38{1'b1}}});
        send_item(OP_TIME, 39'sd951782399);

        run_random(66);
        send_idle_pct = 78;
        recv_idle_pct = 26;
        run_random(66);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(66);
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
